FILE: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator: request and
// response beats, status codes, register indexes and the CSR view.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // request kinds
   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_MEM   = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   // register indexes (byte address 4*index)
   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_WORDS = 1'b1;

   localparam logic [15:0] HEAP_BASE_RESET  = 16'h4000;
   localparam logic [14:0] HEAP_WORDS_RESET = 15'h3000;

   typedef struct packed {
      logic        kind;
      logic [13:0] request_size;
      logic [15:0] data_address;
   } req_type;

   typedef struct packed {
      logic [15:0] granted_address;
      logic [1:0]  status;
   } rsp_type;

   // configuration seen by the allocator core
   typedef struct packed {
      logic [15:0] heap_base;
      logic [14:0] heap_words;
   } cfg_type;

endpackage

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit word heap allocator with splitting and coalescing. A sequencer
// walks the chunk headers in a header memory with one read and one write port.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   req       in         start & !busy          req_payload (req_type)
//   rsp       out        rsp_valid, one cycle   rsp_payload (rsp_type)
//   csr       in/out     psel/penable/pready    pwdata / prdata
//
// Allocate reads the chunk headers in turn until one fits or the top is
// reached; release reads each chunk up to the target, then its neighbours.
// The header memory's single read port (one registered read per chunk)
// sets the pace. Reset is synchronous; the header memory needs no clearing,
// only chunks that were written are ever visited. The response is registered
// in the last step and busy drops with it; the receiver cannot stall.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit
   import ffha_pkg::*;
#(
   parameter int HEAP_DEPTH   = 16384,
   parameter int HEADER_WORDS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int OW = AW + 1;
   localparam int SW = 18;
   localparam logic [SW-1:0] HW = SW'(HEADER_WORDS);

   typedef enum logic [3:0] {
      S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_EXT, S_A_TOP,
      S_R_RD, S_R_CHK, S_R_NRD, S_R_NCHK, S_R_PRD, S_R_PCHK,
      S_R_FIN, S_R_TOP
   } state_type;

   cfg_type cfg;

   ffha_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // header memory: bit 16 in use, bits 15..0 data size
   logic [16:0] hdr_mem [HEAP_DEPTH];
   logic [16:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [16:0]   wr_data;

   state_type   state_ff;
   logic        kind_ff;
   logic [13:0] req_ff;
   logic [15:0] target_ff;
   logic [OW-1:0] off_ff, next_ff, prev_ff, pprev_ff, top_ff;
   logic        prev_vld_ff, pprev_vld_ff;
   logic [15:0] size_ff, rem_ff;
   logic [15:0] grant_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic          rd_used;
   logic [15:0]   rd_size;
   logic [SW-1:0] lim, step_in, new_top_in, fin_end_in, top_rest_in;
   logic [15:0]   target_in;

   assign rd_used = rd_data_ff[16];
   assign rd_size = rd_data_ff[15:0];

   // clamp heap_words to the memory depth
   assign lim = (SW'(cfg.heap_words) > SW'(HEAP_DEPTH)) ? SW'(HEAP_DEPTH)
                                                        : SW'(cfg.heap_words);
   assign step_in    = SW'(off_ff) + HW + SW'(rd_size);
   assign new_top_in = SW'(top_ff) + HW + SW'(req_ff);
   assign fin_end_in = SW'(off_ff) + HW + SW'(size_ff);
   assign top_rest_in = (lim > SW'(top_ff) + HW) ? lim - SW'(top_ff) - HW : '0;
   assign target_in  = req_payload.data_address - cfg.heap_base - 16'(HEADER_WORDS);

   // read address per state
   always_comb begin
      case (state_ff)
         S_R_NRD: rd_addr = next_ff[AW-1:0];
         S_R_PRD: rd_addr = prev_ff[AW-1:0];
         default: rd_addr = off_ff[AW-1:0];
      endcase
   end

   // write port per state
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = off_ff[AW-1:0];
      wr_data = {1'b1, 2'b00, req_ff};
      case (state_ff)
         S_A_CHK: begin
            wr_en = !rd_used && rd_size >= 16'(req_ff);
            if (rd_size - 16'(req_ff) >= 16'(HEADER_WORDS + 1)) begin
               wr_data = {1'b1, 2'b00, req_ff};
            end else begin
               wr_data = {1'b1, rd_size};
            end
         end
         S_A_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = next_ff[AW-1:0];
            wr_data = {1'b0, rem_ff};
         end
         S_A_EXT: begin
            wr_en   = !(new_top_in + HW > lim);
            wr_addr = top_ff[AW-1:0];
         end
         S_A_TOP, S_R_TOP: begin
            wr_en   = 1'b1;
            wr_addr = top_ff[AW-1:0];
            wr_data = {1'b0, top_rest_in[15:0]};
         end
         S_R_FIN: begin
            wr_en   = 1'b1;
            wr_data = {1'b0, size_ff};
         end
         default: ;
      endcase
   end

   // header memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= hdr_mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prev_vld_ff  <= 1'b0;
         pprev_vld_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff      <= req_payload.kind;
                  req_ff       <= req_payload.request_size;
                  target_ff    <= target_in;
                  off_ff       <= '0;
                  prev_vld_ff  <= 1'b0;
                  pprev_vld_ff <= 1'b0;
                  if (req_payload.kind == KIND_ALLOC) begin
                     state_ff <= (top_ff == '0) ? S_A_EXT : S_A_RD;
                  end else if (17'(target_in) >= 17'(top_ff)) begin
                     rsp_ff       <= '{granted_address: 16'd0, status: STATUS_BAD_FREE};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_R_RD;
                  end
               end
            end
            S_A_RD: state_ff <= S_A_CHK;
            S_A_CHK: begin
               if (!rd_used && rd_size >= 16'(req_ff)) begin
                  grant_ff <= cfg.heap_base + 16'(off_ff) + 16'(HEADER_WORDS);
                  next_ff  <= OW'(SW'(off_ff) + HW + SW'(req_ff));
                  rem_ff   <= rd_size - 16'(req_ff) - 16'(HEADER_WORDS);
                  if (rd_size - 16'(req_ff) >= 16'(HEADER_WORDS + 1)) begin
                     state_ff <= S_A_SPLIT;
                  end else begin
                     rsp_ff <= '{granted_address: cfg.heap_base + 16'(off_ff)
                                 + 16'(HEADER_WORDS), status: STATUS_OK};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  off_ff   <= OW'(step_in);
                  state_ff <= (step_in >= SW'(top_ff)) ? S_A_EXT : S_A_RD;
               end
            end
            S_A_SPLIT: begin
               rsp_ff       <= '{granted_address: grant_ff, status: STATUS_OK};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_A_EXT: begin
               if (new_top_in + HW > lim) begin
                  rsp_ff       <= '{granted_address: 16'd0, status: STATUS_NO_MEM};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  grant_ff <= cfg.heap_base + 16'(top_ff) + 16'(HEADER_WORDS);
                  top_ff   <= OW'(new_top_in);
                  state_ff <= S_A_TOP;
               end
            end
            S_A_TOP: begin
               rsp_ff       <= '{granted_address: grant_ff, status: STATUS_OK};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_R_RD: state_ff <= S_R_CHK;
            S_R_CHK: begin
               if (16'(off_ff) == target_ff) begin
                  if (!rd_used) begin
                     rsp_ff       <= '{granted_address: 16'd0, status: STATUS_BAD_FREE};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     size_ff  <= rd_size;
                     next_ff  <= OW'(step_in);
                     if (step_in < SW'(top_ff)) begin
                        state_ff <= S_R_NRD;
                     end else begin
                        state_ff <= prev_vld_ff ? S_R_PRD : S_R_FIN;
                     end
                  end
               end else begin
                  pprev_ff     <= prev_ff;
                  pprev_vld_ff <= prev_vld_ff;
                  prev_ff      <= off_ff;
                  prev_vld_ff  <= 1'b1;
                  off_ff       <= OW'(step_in);
                  if (step_in >= SW'(top_ff)) begin
                     rsp_ff       <= '{granted_address: 16'd0, status: STATUS_BAD_FREE};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     state_ff <= S_R_RD;
                  end
               end
            end
            S_R_NRD: state_ff <= S_R_NCHK;
            S_R_NCHK: begin
               // merge with a free chunk after
               if (!rd_used) begin
                  size_ff <= size_ff + 16'(HEADER_WORDS) + rd_size;
               end
               state_ff <= prev_vld_ff ? S_R_PRD : S_R_FIN;
            end
            S_R_PRD: state_ff <= S_R_PCHK;
            S_R_PCHK: begin
               // merge with a free chunk before
               if (!rd_used) begin
                  size_ff     <= size_ff + 16'(HEADER_WORDS) + rd_size;
                  off_ff      <= prev_ff;
                  prev_ff     <= pprev_ff;
                  prev_vld_ff <= pprev_vld_ff;
               end
               state_ff <= S_R_FIN;
            end
            S_R_FIN: begin
               if (fin_end_in >= SW'(top_ff)) begin
                  top_ff   <= off_ff;
                  state_ff <= S_R_TOP;
               end else begin
                  rsp_ff       <= '{granted_address: 16'd0, status: STATUS_OK};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_R_TOP: begin
               rsp_ff       <= '{granted_address: 16'd0, status: STATUS_OK};
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   // a response never overlaps work in progress
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response while busy");
   // failures and releases carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != STATUS_OK || kind_ff == KIND_RELEASE)
      |-> rsp_payload.granted_address == 16'd0)
      else $error("nonzero address on failure or release");
   // status code stays within its defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status != 2'd3)
      else $error("undefined status");
   // top of heap never reaches the memory end
   assert property (@(posedge clock) disable iff (reset)
      SW'(top_ff) + HW <= SW'(HEAP_DEPTH) || top_ff == '0)
      else $error("top header out of range");
`endif

endmodule

FILE: rtl/core/ffha_csr.sv
// ----------------------------------------------------------------------------
// ffha_csr
// APB-style register block holding heap_base and heap_words.
// ----------------------------------------------------------------------------
module ffha_csr
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [15:0] heap_base_ff;
   logic [14:0] heap_words_ff;
   logic        wr_beat;

   assign csr_pready = 1'b1;
   assign wr_beat    = csr_psel & csr_penable & csr_pwrite;

   // write registers on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= HEAP_BASE_RESET;
         heap_words_ff <= HEAP_WORDS_RESET;
      end else if (wr_beat) begin
         case (csr_paddr[2])
            REG_HEAP_BASE:  heap_base_ff  <= csr_pwdata[15:0];
            REG_HEAP_WORDS: heap_words_ff <= csr_pwdata[14:0];
            default:        ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (csr_paddr[2])
         REG_HEAP_BASE:  csr_prdata = {16'd0, heap_base_ff};
         REG_HEAP_WORDS: csr_prdata = {17'd0, heap_words_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign cfg.heap_base  = heap_base_ff;
   assign cfg.heap_words = heap_words_ff;

endmodule
